[hw/rtl/rdc_pkg.sv]
// Shared types, constants and helpers for the radix digit converter.
`default_nettype none

package rdc_pkg;

    // Fixed field widths
    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 7;
    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Default for the VALUE_BITS parameter of the top level
    localparam int VALUE_BITS_DEF = 32;

    // Dividend bits retired by the divider per cycle
    localparam int STEP_BITS = 8;

    // Register map: register index is paddr[2]
    localparam logic REG_IDX_RADIX = 1'b0;

    // Radix limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // ASCII code points and the decimal digit limit
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A        = 7'd65;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } rdc_state_t;

    // Sequencer to divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_LIMIT)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_W'(d) - CHAR_W'(DECIMAL_LIMIT);
        end
        return c;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        if (r < RADIX_MIN)
        begin
            b = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            b = RADIX_MAX;
        end
        else
        begin
            b = r;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rdc_if.sv]
// Valid/ready stream interfaces for the value input and the digit output.
`default_nettype none

interface rdc_value_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rdc_digit_if;
    logic                       valid;
    logic                       ready;
    logic [rdc_pkg::CHAR_W-1:0] digit_char;
    logic                       last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

[hw/rtl/rdc_divider.sv]
// Iterative restoring divider: value by a small base, STEP_BITS bits per cycle.
`default_nettype none

module rdc_divider #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  rdc_pkg::div_ctrl_t                 ctrl,
    input  wire        [VALUE_BITS-1:0]        dividend,
    input  wire        [rdc_pkg::RADIX_W-1:0]  base,
    output rdc_pkg::div_stat_t                 stat,
    output logic       [VALUE_BITS-1:0]        quotient,
    output logic       [rdc_pkg::DIGIT_W-1:0]  remainder
);

    localparam int SB    = rdc_pkg::STEP_BITS;
    localparam int STEPS = (VALUE_BITS + SB - 1) / SB;
    localparam int QW    = STEPS * SB;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int DW    = rdc_pkg::DIGIT_W;

    logic [QW-1:0]    quo_reg,  quo_next;
    logic [DW-1:0]    rem_reg,  rem_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    // q holds undivided dividend bits on top, quotient bits shifting in below
    logic [QW-1:0] q_step;
    logic [DW-1:0] r_step;

    always_comb
    begin
        logic [DW:0] t;
        q_step = quo_reg;
        r_step = rem_reg;
        for (int i = 0; i < SB; i++)
        begin
            t      = {r_step, q_step[QW-1]};
            q_step = {q_step[QW-2:0], 1'b0};
            if (t >= (DW+1)'(base))
            begin
                t         = t - (DW+1)'(base);
                q_step[0] = 1'b1;
            end
            r_step = t[DW-1:0];
        end
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            quo_next  = QW'(dividend);
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = q_step;
            rem_next = r_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg[VALUE_BITS-1:0];
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[hw/rtl/radix_digit_converter_core.sv]
// Top level of the radix digit converter: sequencer, digit memory, APB register.
//
// Converts each accepted value (low VALUE_BITS bits) into ASCII digits in the
// base held in the radix register (APB byte address 0, 5 bits, reset 10; 0-1
// act as base 2 and 17-31 as base 16). Digits come out one per beat, most
// significant first, with last_digit set on the final one; zero gives a
// single '0'. One item at a time: the input is not ready from acceptance
// until the last digit has been read into the output register. Each digit
// costs one pass of the shared divider, which retires 8 dividend bits a
// cycle; digits are then read back from the digit memory one per cycle
// while the sink keeps up. The output register lets the next value be
// accepted while the final digit still waits. Write the radix only while idle.
`default_nettype none

module radix_digit_converter_core #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    rdc_value_if.sink                         value_ch,
    rdc_digit_if.source                       digit_ch,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire        [rdc_pkg::APB_AW-1:0]  paddr,
    input  wire        [rdc_pkg::APB_DW-1:0]  pwdata,
    output logic       [rdc_pkg::APB_DW-1:0]  prdata,
    output logic                              pready
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int DW    = rdc_pkg::DIGIT_W;
    localparam int RW    = rdc_pkg::RADIX_W;

    // ---------------- config register ----------------
    logic [RW-1:0] radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rdc_pkg::RADIX_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == rdc_pkg::REG_IDX_RADIX))
        begin
            radix_reg <= pwdata[RW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rdc_pkg::REG_IDX_RADIX) ? rdc_pkg::APB_DW'(radix_reg) : '0;

    // ---------------- sequencer state ----------------
    rdc_pkg::rdc_state_t state_reg, state_next;
    logic [RW-1:0]       base_reg,  base_next;     // clamped base for this item
    logic [IDX_W-1:0]    wr_ptr_reg, wr_ptr_next;  // next digit slot to fill
    logic [IDX_W-1:0]    rd_ptr_reg, rd_ptr_next;  // next digit slot to emit
    logic                out_valid_reg, out_valid_next;
    logic                last_reg;
    logic [DW-1:0]       rd_data_reg;

    // Captured input value, fed to the divider on its first pass
    logic [VALUE_BITS-1:0] value_reg;

    // ---------------- shared divider ----------------
    rdc_pkg::div_ctrl_t  div_ctrl;
    rdc_pkg::div_stat_t  div_stat;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DW-1:0]         div_remainder;

    rdc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .base      (base_reg),
        .stat      (div_stat),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Digit memory, least significant digit at slot 0
    logic [DW-1:0] digit_mem [VALUE_BITS];

    logic in_accept;
    logic mem_wr;
    logic mem_rd;

    assign in_accept = value_ch.valid && value_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        out_valid_next = out_valid_reg;
        div_ctrl.start = 1'b0;
        div_dividend   = VALUE_BITS'(value_ch.value);
        mem_wr         = 1'b0;
        mem_rd         = 1'b0;
        value_ch.ready = 1'b0;

        // Output register drains independently of the sequencer
        if (digit_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rdc_pkg::ST_IDLE:
            begin
                value_ch.ready = 1'b1;
                if (value_ch.valid)
                begin
                    // base is the clamped register; divider starts next cycle
                    base_next   = rdc_pkg::clamp_radix(radix_reg);
                    wr_ptr_next = '0;
                    state_next  = rdc_pkg::ST_DIVIDE;
                end
            end
            rdc_pkg::ST_DIVIDE:
            begin
                div_dividend = div_quotient;
                if (!div_stat.busy && !div_stat.done)
                begin
                    // First pass for a freshly accepted value
                    div_ctrl.start = 1'b1;
                    div_dividend   = value_reg;
                end
                else if (div_stat.done)
                begin
                    mem_wr = 1'b1;
                    if ((div_quotient == '0) || (wr_ptr_reg == IDX_W'(VALUE_BITS - 1)))
                    begin
                        rd_ptr_next = wr_ptr_reg;
                        state_next  = rdc_pkg::ST_EMIT;
                    end
                    else
                    begin
                        wr_ptr_next    = wr_ptr_reg + 1'b1;
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            rdc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || digit_ch.ready)
                begin
                    mem_rd         = 1'b1;
                    out_valid_next = 1'b1;
                    if (rd_ptr_reg == '0)
                    begin
                        state_next = rdc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            value_reg <= VALUE_BITS'(value_ch.value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdc_pkg::ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            digit_mem[wr_ptr_reg] <= div_remainder;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_data_reg <= digit_mem[rd_ptr_reg];
            last_reg    <= (rd_ptr_reg == '0);
        end
    end

    assign digit_ch.valid      = out_valid_reg;
    assign digit_ch.digit_char = rdc_pkg::digit_to_ascii(rd_data_reg);
    assign digit_ch.last_digit = last_reg;

endmodule

`default_nettype wire

[hw/rtl/rdc_checker.sv]
// Port-level checker for the radix digit converter, bound to the top level.
`default_nettype none

module rdc_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_ready,
    input wire                         out_valid,
    input wire                         out_ready,
    input wire [rdc_pkg::CHAR_W-1:0]   digit_char,
    input wire                         last_digit
);

    // One item at a time: the input closes right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input stayed ready after accepting a value");

    // More digits are pending while a non-final digit waits
    a_busy_mid_string: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_digit |-> !in_ready)
        else $error("input ready in the middle of a digit string");

    // Only digit characters are produced
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((digit_char >= 7'd48) && (digit_char <= 7'd57)) ||
                      ((digit_char >= 7'd65) && (digit_char <= 7'd70)))
        else $error("digit_char outside 0-9, A-F");

    // A stalled digit beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit))
        else $error("stalled digit beat changed");

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (value_ch.valid),
    .in_ready   (value_ch.ready),
    .out_valid  (digit_ch.valid),
    .out_ready  (digit_ch.ready),
    .digit_char (digit_ch.digit_char),
    .last_digit (digit_ch.last_digit)
);

`default_nettype wire
